// ===== src/activation_function_unit_defines.svh =====
// Assertion helpers shared by the activation unit RTL.
// Both forms expect clk and rst in scope and are off during reset.
`ifndef ACTIVATION_FUNCTION_UNIT_DEFINES_SVH
`define ACTIVATION_FUNCTION_UNIT_DEFINES_SVH

// Same-cycle implication
`define AFU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define AFU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/afu_pkg.sv =====
package afu_pkg;

  // Default geometry
  localparam int DATA_WIDTH_DEF      = 16;
  localparam int FRAC_BITS_DEF       = 12;
  localparam int TABLE_ADDR_BITS_DEF = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_FUNC_SEL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DERIV    = 2'd1;

  // function_select codes
  localparam logic [1:0] FN_RELU    = 2'd0;
  localparam logic [1:0] FN_SIGMOID = 2'd1;
  localparam logic [1:0] FN_TANH    = 2'd2;

  // What the last stages still have to do with an item
  typedef enum logic [1:0] {
    KIND_FWD   = 2'd0,
    KIND_DSIG  = 2'd1,
    KIND_DTANH = 2'd2
  } afu_kind_t;

  // Table build arithmetic, unsigned Q2.30
  localparam longint unsigned Q30_ONE      = 64'h0000_0000_4000_0000;
  localparam int              SERIES_TERMS = 24;

  // Truncating unsigned quotient by shift and subtract, elaboration only
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-f for f in [0, 1.0], truncated Taylor series
  function automatic longint unsigned exp_neg_frac(input longint unsigned f);
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned k;
    term = Q30_ONE;
    pos  = Q30_ONE;
    neg  = 64'd0;
    for (k = 64'd1; k <= longint'(SERIES_TERMS); k++) begin
      term = udiv((term * f) >> 30, k);
      if (k[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return pos - neg;
  endfunction

  // e^-v for v in [0, 8.0): fractional part by series, integer part by e^-1 steps
  function automatic longint unsigned exp_neg(input longint unsigned v);
    longint unsigned einv;
    longint unsigned r;
    longint unsigned n;
    longint unsigned i;
    einv = exp_neg_frac(Q30_ONE);
    r    = exp_neg_frac(v & (Q30_ONE - 64'd1));
    n    = (v >> 30) & 64'd15;
    for (i = 64'd0; i < n; i++) begin
      r = (r * einv) >> 30;
    end
    return r;
  endfunction

  // tanh at the center of table cell idx, rounded to frac_bits
  function automatic longint unsigned tanh_entry(input int unsigned idx,
                                                 input int unsigned frac_bits,
                                                 input int unsigned addr_bits);
    longint unsigned u;
    longint unsigned e;
    longint unsigned t;
    int unsigned     sh;
    sh = 30 - frac_bits;
    u  = (longint'(2 * idx + 1)) << (31 - addr_bits);
    e  = exp_neg(2 * u);
    t  = udiv((Q30_ONE - e) << 30, Q30_ONE + e);
    return (t + (64'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

// ===== src/activation_function_unit.sv =====
// Element-wise activation unit: ReLU, sigmoid or tanh of a signed fixed-point
// value, or the derivative of that function at the value, chosen by the
// function_select and derivative_mode registers (write them only while the
// unit is empty). It takes one item per clock while the output is not stalled;
// each item passes through five register stages: input decode,
// tanh table read, operand forming, multiply, and round/saturate. Sigmoid and
// tanh come from one constant tanh table with odd symmetry, saturating to 1.0
// beyond its span; sigmoid uses s(x) = (1 + tanh(x/2)) / 2. Results are
// saturated to the signed output range and last_out follows last_element.
// A stage holds its item while the stage after it is full and stalled, so
// bubbles close up and back-pressure never drops or repeats an item.
`include "activation_function_unit_defines.svh"

module activation_function_unit #(
  parameter int DATA_WIDTH      = afu_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS       = afu_pkg::FRAC_BITS_DEF,
  parameter int TABLE_ADDR_BITS = afu_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [afu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [afu_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [DATA_WIDTH-1:0]    x_value,
  input  logic                            last_element,
  // output channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [DATA_WIDTH-1:0]    y_value,
  output logic                            last_out
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int AB = TABLE_ADDR_BITS;
  localparam int TW = FB + 1;                       // holds 0 .. 1.0
  localparam int FW = (DW > FB + 2) ? DW : FB + 2;  // signed result before saturation
  localparam int EW = DW + AB;
  localparam int PW = 2 * TW;

  localparam logic [TW-1:0] ONE_T = {1'b1, {FB{1'b0}}};
  localparam logic [PW-1:0] HALF_P = PW'(ONE_T >> 1);
  localparam logic signed [FW-1:0] SAT_HI = FW'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [FW-1:0] SAT_LO = -SAT_HI - FW'(1);

  // Configuration registers
  logic [1:0] fsel;
  logic       dmode;

  always_ff @(posedge clk) begin
    if (rst) begin
      fsel  <= afu_pkg::FN_RELU;
      dmode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        afu_pkg::REG_FUNC_SEL: fsel  <= cfg_data[1:0];
        afu_pkg::REG_DERIV:    dmode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or the next one moves
  logic en_1, en_2, en_3, en_4, en_out;
  logic s1_valid, s2_valid, s3_valid, s4_valid;

  assign en_out   = !out_valid || out_ready;
  assign en_4     = !s4_valid || en_out;
  assign en_3     = !s3_valid || en_4;
  assign en_2     = !s2_valid || en_3;
  assign en_1     = !s1_valid || en_2;
  assign in_ready = en_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_1)   s1_valid  <= in_valid;
      if (en_2)   s2_valid  <= s1_valid;
      if (en_3)   s3_valid  <= s2_valid;
      if (en_4)   s4_valid  <= s3_valid;
      if (en_out) out_valid <= s4_valid;
    end
  end

  // ---- Stage 1: magnitude, table index, span check ----
  logic [DW-1:0] mag;
  logic [EW-1:0] ext;
  logic [EW-1:0] scaled;
  logic          halve;

  assign mag    = x_value[DW-1] ? (~x_value + 1'b1) : x_value;
  assign ext    = {mag, {AB{1'b0}}};
  assign halve  = (fsel == afu_pkg::FN_SIGMOID);
  assign scaled = halve ? (ext >> (FB + 3)) : (ext >> (FB + 2));

  logic signed [DW-1:0] s1_x;
  logic                 s1_last;
  logic                 s1_neg;
  logic                 s1_sat;
  logic [AB-1:0]        s1_idx;

  always_ff @(posedge clk) begin
    if (en_1) begin
      s1_x    <= x_value;
      s1_last <= last_element;
      s1_neg  <= x_value[DW-1];
      s1_sat  <= (scaled >> AB) != '0;
      s1_idx  <= scaled[AB-1:0];
    end
  end

  // ---- Stage 2: table read ----
  logic [TW-1:0]        rom_data;
  logic signed [DW-1:0] s2_x;
  logic                 s2_last;
  logic                 s2_neg;
  logic                 s2_sat;

  afu_tanh_rom #(
    .FRAC_BITS       (FB),
    .TABLE_ADDR_BITS (AB)
  ) u_rom (
    .clk     (clk),
    .rd_en   (en_2),
    .rd_addr (s1_idx),
    .rd_data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (en_2) begin
      s2_x    <= s1_x;
      s2_last <= s1_last;
      s2_neg  <= s1_neg;
      s2_sat  <= s1_sat;
    end
  end

  // ---- Stage 3: sigmoid, forward value, multiplier operands ----
  logic [TW-1:0]        tmag;
  logic [TW:0]          sig_sum;
  logic [TW-1:0]        sig;
  logic                 x_pos;
  logic signed [FW-1:0] fwd;
  afu_pkg::afu_kind_t   kind;
  logic [TW-1:0]        op_a, op_b;

  assign tmag    = s2_sat ? ONE_T : rom_data;
  assign sig_sum = s2_neg ? ({1'b0, ONE_T} - {1'b0, tmag} + (TW+1)'(1))
                          : ({1'b0, ONE_T} + {1'b0, tmag} + (TW+1)'(1));
  assign sig     = sig_sum[TW:1];
  assign x_pos   = !s2_x[DW-1] && (s2_x != '0);

  always_comb begin
    fwd  = '0;
    kind = afu_pkg::KIND_FWD;
    op_a = tmag;
    op_b = tmag;
    case (fsel)
      afu_pkg::FN_RELU: begin
        if (dmode) fwd = x_pos ? $signed(FW'(ONE_T)) : '0;
        else       fwd = x_pos ? FW'(s2_x) : '0;
      end
      afu_pkg::FN_SIGMOID: begin
        fwd  = $signed(FW'(sig));
        op_a = sig;
        op_b = ONE_T - sig;
        if (dmode) kind = afu_pkg::KIND_DSIG;
      end
      afu_pkg::FN_TANH: begin
        fwd = s2_neg ? -$signed(FW'(tmag)) : $signed(FW'(tmag));
        if (dmode) kind = afu_pkg::KIND_DTANH;
      end
      default: fwd = '0;
    endcase
  end

  logic                 s3_last;
  afu_pkg::afu_kind_t   s3_kind;
  logic signed [FW-1:0] s3_fwd;
  logic [TW-1:0]        s3_mul_a, s3_mul_b;

  always_ff @(posedge clk) begin
    if (en_3) begin
      s3_last  <= s2_last;
      s3_kind  <= kind;
      s3_fwd   <= fwd;
      s3_mul_a <= op_a;
      s3_mul_b <= op_b;
    end
  end

  // ---- Stage 4: multiply ----
  logic                 s4_last;
  afu_pkg::afu_kind_t   s4_kind;
  logic signed [FW-1:0] s4_fwd;
  logic [PW-1:0]        s4_prod;

  always_ff @(posedge clk) begin
    if (en_4) begin
      s4_last <= s3_last;
      s4_kind <= s3_kind;
      s4_fwd  <= s3_fwd;
      s4_prod <= PW'(s3_mul_a) * PW'(s3_mul_b);
    end
  end

  // ---- Stage 5: round, derivative select, saturate ----
  logic [PW-1:0]        rnd_sum;
  logic [TW-1:0]        rnd;
  logic signed [FW-1:0] res;
  logic signed [DW-1:0] res_sat;

  assign rnd_sum = s4_prod + HALF_P;
  assign rnd     = rnd_sum[FB +: TW];

  always_comb begin
    case (s4_kind)
      afu_pkg::KIND_DSIG:  res = $signed(FW'(rnd));
      afu_pkg::KIND_DTANH: res = $signed(FW'(ONE_T) - FW'(rnd));
      default:             res = s4_fwd;
    endcase
    if (res > SAT_HI)      res_sat = SAT_HI[DW-1:0];
    else if (res < SAT_LO) res_sat = SAT_LO[DW-1:0];
    else                   res_sat = res[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      y_value  <= res_sat;
      last_out <= s4_last;
    end
  end

  // ---- Checks ----
  `AFU_ASSERT_NOW(a_ready_chain, out_ready, in_ready,
    "input not ready although output is being drained")
  `AFU_ASSERT_NEXT(a_s4_hold, s4_valid && !en_out, s4_valid && $stable(s4_prod),
    "multiply stage lost its item during a stall")
  `AFU_ASSERT_NOW(a_tanh_square, s3_valid && (s3_kind == afu_pkg::KIND_DTANH),
    s3_mul_a == s3_mul_b, "tanh derivative operands differ")
  `AFU_ASSERT_NOW(a_sigmoid_nonneg, out_valid && (fsel == afu_pkg::FN_SIGMOID),
    !y_value[DW-1], "negative sigmoid result")

endmodule

// ===== src/afu_tanh_rom.sv =====
// Constant tanh table over [0, 4.0), one cell per step, registered read.
module afu_tanh_rom #(
  parameter int FRAC_BITS       = afu_pkg::FRAC_BITS_DEF,
  parameter int TABLE_ADDR_BITS = afu_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [TABLE_ADDR_BITS-1:0] rd_addr,
  output logic [FRAC_BITS:0]         rd_data
);

  localparam int DEPTH = 1 << TABLE_ADDR_BITS;
  localparam int TW    = FRAC_BITS + 1;

  logic [TW-1:0] table_data [DEPTH];

  // Contents are fixed at elaboration
  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    localparam longint unsigned ENTRY =
      afu_pkg::tanh_entry(g, FRAC_BITS, TABLE_ADDR_BITS);
    assign table_data[g] = ENTRY[TW-1:0];
  end

  // Read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= table_data[rd_addr];
    end
  end

endmodule

// ===== bench/activation_function_unit_test.sv =====
`timescale 1ns / 100ps

module activation_function_unit_test;
  import afu_pkg::*;

  localparam int DW    = DATA_WIDTH_DEF;
  localparam int FB    = FRAC_BITS_DEF;
  localparam int AB    = TABLE_ADDR_BITS_DEF;
  localparam int TSIZE = 1 << AB;

  // Codes the package leaves unnamed
  localparam logic [1:0]             FN_UNUSED    = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam int N_DIRECTED    = 24;
  localparam int N_PHASES      = 10;
  localparam int PHASE_ITEMS   = 200;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 120;
  localparam int STALL_LIMIT   = 2000;

  localparam longint unsigned UNIT_Q30 = 64'd1 << 30;

  typedef struct {
    logic [1:0]            fsel;
    logic                  deriv;
    logic signed [DW-1:0]  x;
    logic                  is_last;
    bit                    typed;
    logic signed [DW-1:0]  y;
  } vector_t;

  typedef struct {
    logic signed [DW-1:0] y;
    logic                 is_last;
  } result_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic signed [DW-1:0]   x_value;
  logic                   last_element;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [DW-1:0]   y_value;
  logic                   last_out;

  // Register mirror and the results still owed by the block
  logic [1:0]      cur_fsel;
  logic            cur_deriv;
  result_t         pending_results[$];
  longint unsigned tanh_table [TSIZE];
  int              mismatches = 0;
  int              results_seen = 0;
  bit              calm = 1'b0;

  // Directed items; y is typed in only where it is plain from the definition
  vector_t directed_vectors [N_DIRECTED] = '{
    '{FN_RELU,    1'b0, 16'sd0,      1'b0, 1'b1, 16'sd0},
    '{FN_RELU,    1'b0, 16'sh7fff,   1'b0, 1'b1, 16'sh7fff},
    '{FN_RELU,    1'b0, 16'sh8000,   1'b1, 1'b1, 16'sd0},
    '{FN_RELU,    1'b0, 16'sd1,      1'b0, 1'b1, 16'sd1},
    '{FN_RELU,    1'b1, 16'sd1,      1'b0, 1'b1, 16'sd4096},
    '{FN_RELU,    1'b1, 16'sd0,      1'b0, 1'b1, 16'sd0},
    '{FN_RELU,    1'b1, 16'sh8000,   1'b1, 1'b1, 16'sd0},
    '{FN_SIGMOID, 1'b0, 16'sh8000,   1'b0, 1'b1, 16'sd0},
    '{FN_SIGMOID, 1'b0, 16'sh7fff,   1'b0, 1'b0, 16'sd0},
    '{FN_SIGMOID, 1'b0, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{FN_SIGMOID, 1'b0, -16'sd1,     1'b1, 1'b0, 16'sd0},
    '{FN_SIGMOID, 1'b1, 16'sh8000,   1'b0, 1'b1, 16'sd0},
    '{FN_SIGMOID, 1'b1, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{FN_SIGMOID, 1'b1, 16'sh7fff,   1'b1, 1'b0, 16'sd0},
    '{FN_TANH,    1'b0, 16'sh7fff,   1'b0, 1'b1, 16'sd4096},
    '{FN_TANH,    1'b0, 16'sh8000,   1'b0, 1'b1, -16'sd4096},
    '{FN_TANH,    1'b0, 16'sd16384,  1'b0, 1'b1, 16'sd4096},
    '{FN_TANH,    1'b0, 16'sd16383,  1'b0, 1'b0, 16'sd0},
    '{FN_TANH,    1'b0, -16'sd16384, 1'b1, 1'b1, -16'sd4096},
    '{FN_TANH,    1'b0, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{FN_TANH,    1'b1, 16'sh7fff,   1'b0, 1'b1, 16'sd0},
    '{FN_TANH,    1'b1, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{FN_UNUSED,  1'b0, 16'sd12345,  1'b1, 1'b1, 16'sd0},
    '{FN_UNUSED,  1'b1, 16'sh8000,   1'b0, 1'b1, 16'sd0}
  };

  activation_function_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .x_value      (x_value),
    .last_element (last_element),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .y_value      (y_value),
    .last_out     (last_out)
  );

  always #6 clk = ~clk;

  // e^-f in Q2.30 for f in [0, 1.0], 24-term truncated series
  function automatic longint unsigned q30_exp_neg_unit(input longint unsigned f);
    longint unsigned term, pos, neg, k;
    term = UNIT_Q30;
    pos  = UNIT_Q30;
    neg  = 0;
    for (k = 1; k <= 24; k++) begin
      term = ((term * f) >> 30) / k;
      if (k[0]) begin
        neg += term;
      end else begin
        pos += term;
      end
    end
    return pos - neg;
  endfunction

  // e^-v in Q2.30 for v in [0, 8.0): fraction by series, whole part by e^-1 steps
  function automatic longint unsigned q30_exp_neg(input longint unsigned v);
    longint unsigned e1, r, n, i;
    e1 = q30_exp_neg_unit(UNIT_Q30);
    r  = q30_exp_neg_unit(v & (UNIT_Q30 - 1));
    n  = (v >> 30) & 15;
    for (i = 0; i < n; i++) begin
      r = (r * e1) >> 30;
    end
    return r;
  endfunction

  // tanh at each cell center over [0, 4.0), rounded half up
  initial begin : build_table
    longint unsigned u, e, t;
    int sh;
    sh = 30 - FB;
    for (int i = 0; i < TSIZE; i++) begin
      u = longint'(2 * i + 1) << (31 - AB);
      e = q30_exp_neg(2 * u);
      t = ((UNIT_Q30 - e) << 30) / (UNIT_Q30 + e);
      tanh_table[i] = (t + (64'd1 << (sh - 1))) >> sh;
    end
  end

  // tanh(xv / 2^halve) from the table, odd symmetric, 1.0 past the span
  function automatic longint tanh_at(input longint xv, input int halve);
    longint unsigned mag, span;
    longint t;
    mag  = (xv < 0) ? longint'(-xv) : xv;
    span = 64'd4 << (FB + halve);
    if (mag >= span) begin
      t = longint'(1) << FB;
    end else begin
      t = longint'(tanh_table[((mag << AB) >> (FB + 2 + halve)) & (TSIZE - 1)]);
    end
    return (xv < 0) ? -t : t;
  endfunction

  function automatic logic signed [DW-1:0] activation_of(input logic signed [DW-1:0] x,
                                                         input logic [1:0] fsel,
                                                         input logic deriv);
    longint xv, y, s, t, unity, hi, lo;
    xv    = x;
    unity = longint'(1) << FB;
    y     = 0;
    case (fsel)
      FN_RELU: begin
        if (deriv) begin
          y = (xv > 0) ? unity : 0;
        end else begin
          y = (xv > 0) ? xv : 0;
        end
      end
      FN_SIGMOID: begin
        s = (unity + tanh_at(xv, 1) + 1) >>> 1;
        y = deriv ? ((s * (unity - s) + unity / 2) >>> FB) : s;
      end
      FN_TANH: begin
        t = tanh_at(xv, 0);
        y = deriv ? (unity - ((t * t + unity / 2) >>> FB)) : t;
      end
      default: begin
        y = 0;
      end
    endcase
    // saturate to the output range
    hi = (longint'(1) << (DW - 1)) - 1;
    lo = -hi - 1;
    if (y > hi) y = hi;
    if (y < lo) y = lo;
    return y[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] pick_x();
    logic [31:0] r;
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sd0;
          3: return 16'sd16384;
          4: return -16'sd16384;
          default: return -16'sd1;
        endcase
      end
      1, 2, 3, 4: begin
        r = $urandom;
        return r[DW-1:0];
      end
      default: begin
        // mostly inside the table span
        v = int'($urandom_range(0, 40000)) - 20000;
        return v[DW-1:0];
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%t mismatch: %s", $realtime, msg);
    end
  endtask

  // Register write; cfg_we drops again before the task returns, keeping back-to-back writes apart
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_FUNC_SEL) begin
      cur_fsel = data;
    end else if (idx == REG_DERIV) begin
      cur_deriv = data[0];
    end
  endtask

  // Offer one item, hold it until taken, then log what it must produce
  task automatic send_item(input logic signed [DW-1:0] x, input logic is_last,
                           input bit typed, input logic signed [DW-1:0] y_typed);
    result_t r;
    int gap;
    in_valid     <= 1'b1;
    x_value      <= x;
    last_element <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r.y       = typed ? y_typed : activation_of(x, cur_fsel, cur_deriv);
    r.is_last = is_last;
    pending_results.push_back(r);
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and let the pipeline empty out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Main stimulus
  initial begin : stimulus
    logic [1:0] fsel;
    logic       deriv;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    x_value      = '0;
    last_element = 1'b0;
    rst          = 1'b1;
    cur_fsel     = FN_RELU;
    cur_deriv    = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // writes past the register list must leave the reset setting alone
    write_reg(REG_SPARE_LO, 2'b11);
    write_reg(REG_SPARE_HI, 2'b11);

    foreach (directed_vectors[i]) begin
      if (directed_vectors[i].fsel != cur_fsel || directed_vectors[i].deriv != cur_deriv) begin
        settle();
        write_reg(REG_FUNC_SEL, directed_vectors[i].fsel);
        write_reg(REG_DERIV, {1'b0, directed_vectors[i].deriv});
      end
      send_item(directed_vectors[i].x, directed_vectors[i].is_last,
                directed_vectors[i].typed, directed_vectors[i].y);
    end

    // Random phases, each with a function and derivative setting taken from the phase number
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      fsel  = p[1:0];
      deriv = p[2];
      calm  = (p % 4 == 3);
      write_reg(REG_FUNC_SEL, fsel);
      write_reg(REG_DERIV, {1'($urandom_range(0, 1)), deriv});
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(pick_x(), ($urandom_range(0, 7) == 0), 1'b0, '0);
      end
    end
    settle();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("activation_function_unit verification clean");
    end else begin
      $display("activation_function_unit verification failed");
    end
    $finish;
  end

  // Receiver: random stalls, plus two long hold-offs that back the block up
  initial begin : sink
    int gap;
    result_t want;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (results_seen == 330 || results_seen == 1050) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected item y=%0d last=%0b", y_value, last_out));
      end else begin
        want = pending_results.pop_front();
        if (y_value !== want.y) begin
          flag_mismatch($sformatf("y_value expected %0d got %0d", want.y, y_value));
        end
        if (last_out !== want.is_last) begin
          flag_mismatch($sformatf("last_out expected %0b got %0b", want.is_last, last_out));
        end
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("activation_function_unit verification failed");
    $finish;
  end

endmodule
